### design/mdc_pkg.sv
// shared types and constants for the microcoded datapath cycle unit
`default_nettype none

package mdc_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned NUM_REGS  = 9;
	localparam int unsigned SHIFT_L   = 8;
	localparam int unsigned CTL_W     = 8;
	localparam int unsigned SEL_W     = 4;

	// alu function codes
	typedef enum logic [1:0] {
		FN_AND  = 2'd0,
		FN_OR   = 2'd1,
		FN_NOTB = 2'd2,
		FN_ADD  = 2'd3
	} alu_fn_t;

	// control field, msb first, same bit order as alu_control
	typedef struct packed {
		logic    sll8;
		logic    sra1;
		alu_fn_t fn;
		logic    ena;
		logic    enb;
		logic    inva;
		logic    inc;
	} alu_ctl_t;

	// b bus select codes
	localparam logic [SEL_W-1:0] BSEL_MDR   = 4'd0;
	localparam logic [SEL_W-1:0] BSEL_PC    = 4'd1;
	localparam logic [SEL_W-1:0] BSEL_MBRU  = 4'd2;
	localparam logic [SEL_W-1:0] BSEL_MBR   = 4'd3;
	localparam logic [SEL_W-1:0] BSEL_SP    = 4'd4;
	localparam logic [SEL_W-1:0] BSEL_LV    = 4'd5;
	localparam logic [SEL_W-1:0] BSEL_CPP   = 4'd6;
	localparam logic [SEL_W-1:0] BSEL_TOS   = 4'd7;
	localparam logic [SEL_W-1:0] BSEL_OPC   = 4'd8;

	// register file slots, also the write mask bit positions
	localparam int unsigned REG_H   = 0;
	localparam int unsigned REG_OPC = 1;
	localparam int unsigned REG_TOS = 2;
	localparam int unsigned REG_CPP = 3;
	localparam int unsigned REG_LV  = 4;
	localparam int unsigned REG_SP  = 5;
	localparam int unsigned REG_PC  = 6;
	localparam int unsigned REG_MDR = 7;
	localparam int unsigned REG_MAR = 8;

endpackage

`default_nettype wire

### design/mdc_regfile.sv
// datapath register file, byte register and b bus selection
`default_nettype none

module mdc_regfile (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [mdc_pkg::BYTE_W-1:0]        cfg_byte,
	input  wire logic                              wr_en,
	input  wire logic [mdc_pkg::NUM_REGS-1:0]      wr_mask,
	input  wire logic [mdc_pkg::DATA_W-1:0]        wr_data,
	input  wire logic [mdc_pkg::SEL_W-1:0]         b_sel,
	output logic      [mdc_pkg::DATA_W-1:0]        h_data,
	output logic      [mdc_pkg::DATA_W-1:0]        b_data
);

	logic [mdc_pkg::DATA_W-1:0] regs_q [mdc_pkg::NUM_REGS];
	logic [mdc_pkg::BYTE_W-1:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mdc_pkg::NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
			byte_q <= '0;
		end else begin
			if (cfg_we) begin
				byte_q <= cfg_byte;
			end
			for (int i = 0; i < mdc_pkg::NUM_REGS; i++) begin
				if (wr_en && wr_mask[i]) begin
					regs_q[i] <= wr_data;
				end
			end
		end
	end

	assign h_data = regs_q[mdc_pkg::REG_H];

	always_comb begin
		unique case (b_sel)
			mdc_pkg::BSEL_MDR:  b_data = regs_q[mdc_pkg::REG_MDR];
			mdc_pkg::BSEL_PC:   b_data = regs_q[mdc_pkg::REG_PC];
			mdc_pkg::BSEL_MBRU: b_data = {{(mdc_pkg::DATA_W-mdc_pkg::BYTE_W){1'b0}}, byte_q};
			mdc_pkg::BSEL_MBR:  b_data = {{(mdc_pkg::DATA_W-mdc_pkg::BYTE_W){byte_q[mdc_pkg::BYTE_W-1]}},
				byte_q};
			mdc_pkg::BSEL_SP:   b_data = regs_q[mdc_pkg::REG_SP];
			mdc_pkg::BSEL_LV:   b_data = regs_q[mdc_pkg::REG_LV];
			mdc_pkg::BSEL_CPP:  b_data = regs_q[mdc_pkg::REG_CPP];
			mdc_pkg::BSEL_TOS:  b_data = regs_q[mdc_pkg::REG_TOS];
			mdc_pkg::BSEL_OPC:  b_data = regs_q[mdc_pkg::REG_OPC];
			default:            b_data = '0;
		endcase
	end

endmodule

`default_nettype wire

### design/mdc_alu.sv
// alu and shifter
`default_nettype none

module mdc_alu (
	input  wire mdc_pkg::alu_ctl_t            ctl,
	input  wire logic [mdc_pkg::DATA_W-1:0]   h_data,
	input  wire logic [mdc_pkg::DATA_W-1:0]   b_data,
	output logic      [mdc_pkg::DATA_W-1:0]   result,
	output logic                              carry
);

	logic [mdc_pkg::DATA_W-1:0] a_op;
	logic [mdc_pkg::DATA_W-1:0] b_op;
	logic [mdc_pkg::DATA_W-1:0] alu_out;
	logic [mdc_pkg::DATA_W:0]   sum;

	always_comb begin
		a_op = ctl.ena ? h_data : '0;
		if (ctl.inva) begin
			a_op = ~a_op;
		end
		b_op = ctl.enb ? b_data : '0;
		sum  = {1'b0, a_op} + {1'b0, b_op} + {{mdc_pkg::DATA_W{1'b0}}, ctl.inc};

		carry = 1'b0;
		unique case (ctl.fn)
			mdc_pkg::FN_AND:  alu_out = a_op & b_op;
			mdc_pkg::FN_OR:   alu_out = a_op | b_op;
			mdc_pkg::FN_NOTB: alu_out = ~b_op;
			mdc_pkg::FN_ADD: begin
				alu_out = sum[mdc_pkg::DATA_W-1:0];
				carry   = sum[mdc_pkg::DATA_W];
			end
			default:          alu_out = '0;
		endcase

		// sll8 wins over sra1
		if (ctl.sll8) begin
			result = alu_out << mdc_pkg::SHIFT_L;
		end else if (ctl.sra1) begin
			result = {alu_out[mdc_pkg::DATA_W-1], alu_out[mdc_pkg::DATA_W-1:1]};
		end else begin
			result = alu_out;
		end
	end

endmodule

`default_nettype wire

### design/microcoded_datapath_cycle_unit.sv
// top level of the microcoded datapath cycle unit
// runs one microinstruction per item on a nine-register datapath
//
// input channel: alu_control, c_write_mask and b_select with in_valid;
//   the unit raises in_stall to hold an item off
// output channel: shifted_result and its n, z and carry flags with
//   out_valid; the receiver raises out_stall to hold a result
// config channel: cfg_valid/cfg_ready write memory_byte_value into the
//   byte register; cfg_ready is always high, write only while idle
// path: an accepted item lands in the input register, then its result loads
//   into the result register, which drives the output
// throughput: one item per clock while the receiver does not stall; register
//   read, alu, shift and write-back all happen between the input and result
//   registers, so the next item sees the previous item's writes
// receiver stall: the result register holds; the input register takes an item
//   only while empty, then in_stall rises until the result is taken
// reset: all datapath registers and the byte register clear to zero,
//   both pipeline registers empty
`default_nettype none

module microcoded_datapath_cycle_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// input channel
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [mdc_pkg::CTL_W-1:0]        alu_control,
	input  wire logic [mdc_pkg::NUM_REGS-1:0]     c_write_mask,
	input  wire logic [mdc_pkg::SEL_W-1:0]        b_select,
	// config channel
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [mdc_pkg::BYTE_W-1:0]       memory_byte_value,
	// output channel
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic      [mdc_pkg::DATA_W-1:0]       shifted_result,
	output logic                                  negative_flag,
	output logic                                  zero_flag,
	output logic                                  carry_out
);

	// input register
	logic                          valid_s1;
	mdc_pkg::alu_ctl_t             ctl_s1;
	logic [mdc_pkg::NUM_REGS-1:0]  mask_s1;
	logic [mdc_pkg::SEL_W-1:0]     bsel_s1;

	// result register
	logic                          out_valid_q;
	logic [mdc_pkg::DATA_W-1:0]    result_q;
	logic                          carry_q;

	logic                          advance;
	logic                          load_s1;
	logic [mdc_pkg::DATA_W-1:0]    h_data;
	logic [mdc_pkg::DATA_W-1:0]    b_data;
	logic [mdc_pkg::DATA_W-1:0]    alu_shifted;
	logic                          alu_carry;

	// result register free, or being emptied this edge
	assign advance  = !out_valid_q || !out_stall;
	// input register free, or its item moves on this edge
	assign load_s1  = !valid_s1 || advance;
	assign in_stall = !load_s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			ctl_s1  <= mdc_pkg::alu_ctl_t'(alu_control);
			mask_s1 <= c_write_mask;
			bsel_s1 <= b_select;
		end
	end

	mdc_regfile u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_byte (memory_byte_value),
		.wr_en    (valid_s1 && advance),
		.wr_mask  (mask_s1),
		.wr_data  (alu_shifted),
		.b_sel    (bsel_s1),
		.h_data   (h_data),
		.b_data   (b_data)
	);

	mdc_alu u_alu (
		.ctl    (ctl_s1),
		.h_data (h_data),
		.b_data (b_data),
		.result (alu_shifted),
		.carry  (alu_carry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= alu_shifted;
			carry_q  <= alu_carry;
		end
	end

	assign out_valid      = out_valid_q;
	assign shifted_result = result_q;
	assign negative_flag  = result_q[mdc_pkg::DATA_W-1];
	assign zero_flag      = (result_q == '0);
	assign carry_out      = carry_q;

endmodule

`default_nettype wire

### design/mdc_checker.sv
// port-level checker for the microcoded datapath cycle unit, with its bind
`default_nettype none

module mdc_checker (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_stall,
	input  wire logic                             out_valid,
	input  wire logic                             out_stall,
	input  wire logic [mdc_pkg::DATA_W-1:0]       shifted_result,
	input  wire logic                             negative_flag,
	input  wire logic                             zero_flag
);

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// flags agree with the result they travel with
	a_neg_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> negative_flag == shifted_result[mdc_pkg::DATA_W-1])
		else $error("negative flag mismatch");

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> zero_flag == (shifted_result == '0))
		else $error("zero flag mismatch");

	// unit only pushes back while the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with output free");

	// an edge seen in reset leaves nothing offered
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result offered during reset");

endmodule

bind microcoded_datapath_cycle_unit mdc_checker u_mdc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.shifted_result (shifted_result),
	.negative_flag  (negative_flag),
	.zero_flag      (zero_flag)
);

`default_nettype wire
